### hw/rtl/nearest_palette_color_assert.svh
// assertion macros used by the palette quantiser rtl
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// same-cycle implication
`define NPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/npc_pkg.sv
// shared constants and types of the palette quantiser
`default_nettype none

package npc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int DIST_W = 18;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic              is_pixel;
    logic [ADDR_W-1:0] addr;
    rgb_t              color;
    logic [CNT_W-1:0]  n;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ISSUE,
    B_FINISH
  } back_state_t;

endpackage

`default_nettype wire

### hw/rtl/npc_if.sv
// valid/ready channel interfaces of the palette quantiser
`default_nettype none

interface npc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] entry_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, cmd, entry_index, red_in, green_in, blue_in, input ready);
  modport sink (input valid, cmd, entry_index, red_in, green_in, blue_in, output ready);
endinterface

interface npc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] best_index;

  modport source (output valid, red_out, green_out, blue_out, best_index, input ready);
  modport sink (input valid, red_out, green_out, blue_out, best_index, output ready);
endinterface

interface npc_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] palette_count;

  modport source (output valid, palette_count, input ready);
  modport sink (input valid, palette_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/nearest_palette_color.sv
// Nearest palette colour quantiser. Load beats (cmd 0) write one RGB888 palette entry and give
// no result; pixel beats (cmd 1) return the entry with the smallest squared distance among the
// first palette_count entries, lowest index on a tie, and entry 0 when the count is zero. A
// two-deep queue separates acceptance from execution, so beats are taken while a search runs
// or a result waits. A pixel walks n = max(1, min(palette_count, 256)) entries: the palette RAM
// has one read port and is walked one entry per cycle, followed by a distance stage, a compare
// stage and the result register. The user must write palette_count only while the block is idle;
// the block itself does not enforce it. The palette clears at reset.
`default_nettype none

module nearest_palette_color (
  input  wire logic clk,
  input  wire logic rst,
  npc_in_if.sink    item,
  npc_cfg_if.sink   cfg,
  npc_out_if.source result
);

  logic          push;
  npc_pkg::job_t push_data;
  logic          full;
  logic          pop;
  npc_pkg::job_t pop_data;
  logic          empty;

  npc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  npc_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  npc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (pop_data),
    .q_empty (empty),
    .q_pop   (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

### hw/rtl/npc_ram.sv
// generic single write port ram with registered read
`default_nettype none

module npc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/npc_fifo.sv
// short job queue between front and back
`default_nettype none

module npc_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire npc_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output npc_pkg::job_t      pop_data,
  output logic               empty
);

  npc_pkg::job_t                   slots [npc_pkg::QDEPTH];
  logic [npc_pkg::QPTR_W-1:0]      wptr;
  logic [npc_pkg::QPTR_W-1:0]      rptr;
  logic [npc_pkg::QCNT_W-1:0]      count;

  assign full     = (count == npc_pkg::QCNT_W'(npc_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == npc_pkg::QPTR_W'(npc_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == npc_pkg::QPTR_W'(npc_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/npc_front.sv
// input side: count register, beat acceptance and job building
`default_nettype none

module npc_front (
  input  wire logic     clk,
  input  wire logic     rst,
  npc_in_if.sink        item,
  npc_cfg_if.sink       cfg,
  output logic          push,
  output npc_pkg::job_t push_data,
  input  wire logic     full
);

  logic [8:0]                palette_count;
  logic [npc_pkg::CNT_W-1:0] n;
  logic                      in_range;
  logic                      accept;

  assign cfg.ready  = 1'b1;
  assign item.ready = !full;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      palette_count <= cfg.palette_count;
    end
  end

  // entries to walk, at least one so an empty palette yields entry 0
  always_comb begin
    if (int'(palette_count) > npc_pkg::PALETTE_DEPTH) begin
      n = npc_pkg::CNT_W'(npc_pkg::PALETTE_DEPTH);
    end else if (palette_count == '0) begin
      n = npc_pkg::CNT_W'(1);
    end else begin
      n = npc_pkg::CNT_W'(palette_count);
    end
  end

  assign in_range = int'(item.entry_index) < npc_pkg::PALETTE_DEPTH;

  // out-of-range loads are dropped here
  assign push = accept && ((item.cmd == npc_pkg::CMD_PIXEL) || in_range);

  always_comb begin
    push_data.is_pixel = (item.cmd == npc_pkg::CMD_PIXEL);
    push_data.addr     = npc_pkg::ADDR_W'(item.entry_index);
    push_data.color.r  = item.red_in;
    push_data.color.g  = item.green_in;
    push_data.color.b  = item.blue_in;
    push_data.n        = n;
  end

endmodule

`default_nettype wire

### hw/rtl/npc_back.sv
// execution side: palette writes and the nearest-entry search
`default_nettype none
`include "nearest_palette_color_assert.svh"

module npc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire npc_pkg::job_t q_data,
  input  wire logic          q_empty,
  output logic               q_pop,
  npc_out_if.source          result
);

  npc_pkg::back_state_t              state;
  npc_pkg::back_state_t              state_next;

  logic                              ram_we;
  logic                              start;
  logic                              rd_en;
  logic                              last;
  logic                              load_out;
  logic                              drained;

  logic [npc_pkg::PALETTE_DEPTH-1:0] vbits;
  logic [npc_pkg::ADDR_W-1:0]        raddr;
  logic [$bits(npc_pkg::rgb_t)-1:0]  rdata;

  npc_pkg::rgb_t                     pix;
  logic [npc_pkg::CNT_W-1:0]         n;
  logic [npc_pkg::CNT_W-1:0]         issue_idx;

  logic                              s1_v;
  logic [npc_pkg::ADDR_W-1:0]        s1_idx;
  logic                              vld_q;
  npc_pkg::rgb_t                     s1_color;
  logic [npc_pkg::DIST_W-1:0]        s1_dist;

  logic                              s2_v;
  logic [npc_pkg::ADDR_W-1:0]        s2_idx;
  npc_pkg::rgb_t                     s2_color;
  logic [npc_pkg::DIST_W-1:0]        s2_dist;

  logic                              have;
  logic [npc_pkg::DIST_W-1:0]        best_d;
  logic [npc_pkg::ADDR_W-1:0]        best_idx;
  npc_pkg::rgb_t                     best_color;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  assign raddr   = issue_idx[npc_pkg::ADDR_W-1:0];
  assign drained = !s1_v && !s2_v;

  npc_ram #(
    .WIDTH ($bits(npc_pkg::rgb_t)),
    .DEPTH (npc_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_data.addr),
    .wdata (q_data.color),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      npc_pkg::B_IDLE: begin
        if (!q_empty && q_data.is_pixel) begin
          state_next = npc_pkg::B_ISSUE;
        end
      end
      npc_pkg::B_ISSUE: begin
        if (issue_idx == npc_pkg::CNT_W'(n - 1'b1)) begin
          state_next = npc_pkg::B_FINISH;
        end
      end
      npc_pkg::B_FINISH: begin
        if (drained && (!result.valid || result.ready)) begin
          state_next = npc_pkg::B_IDLE;
        end
      end
      default: state_next = npc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    case (state)
      npc_pkg::B_IDLE:   q_pop = !q_empty;
      npc_pkg::B_ISSUE:  rd_en = 1'b1;
      npc_pkg::B_FINISH: load_out = drained && (!result.valid || result.ready);
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign ram_we = q_pop && !q_data.is_pixel;
  assign start  = q_pop && q_data.is_pixel;
  assign last   = rd_en && (issue_idx == npc_pkg::CNT_W'(n - 1'b1));

  // never-written entries read as zero
  assign s1_color = vld_q ? npc_pkg::rgb_t'(rdata) : '0;
  assign s1_dist  = npc_pkg::DIST_W'(sq_diff(pix.r, s1_color.r))
                  + npc_pkg::DIST_W'(sq_diff(pix.g, s1_color.g))
                  + npc_pkg::DIST_W'(sq_diff(pix.b, s1_color.b));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= npc_pkg::B_IDLE;
      vbits        <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      have         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        vbits[q_data.addr] <= 1'b1;
      end
      s1_v <= rd_en;
      s2_v <= s1_v;
      if (start) begin
        have <= 1'b0;
      end else if (s2_v) begin
        have <= 1'b1;
      end
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pix       <= q_data.color;
      n         <= q_data.n;
      issue_idx <= '0;
    end else if (rd_en && !last) begin
      issue_idx <= issue_idx + 1'b1;
    end
    if (rd_en) begin
      s1_idx <= raddr;
      vld_q  <= vbits[raddr];
    end
    s2_idx   <= s1_idx;
    s2_color <= s1_color;
    s2_dist  <= s1_dist;
    // strict compare keeps the lowest index on a tie
    if (s2_v && (!have || (s2_dist < best_d))) begin
      best_d     <= s2_dist;
      best_idx   <= s2_idx;
      best_color <= s2_color;
    end
    if (load_out) begin
      result.red_out    <= best_color.r;
      result.green_out  <= best_color.g;
      result.blue_out   <= best_color.b;
      result.best_index <= 8'(best_idx);
    end
  end

  `NPC_ASSERT_NOW(a_idle_drained, clk, rst, state == npc_pkg::B_IDLE, drained, "search pipeline busy while idle")
  `NPC_ASSERT_NOW(a_issue_bound, clk, rst, state == npc_pkg::B_ISSUE, issue_idx < n, "read beyond search count")
  `NPC_ASSERT_NEXT(a_best_shrinks, clk, rst, s2_v && have, best_d <= $past(best_d), "best distance grew")
  `NPC_ASSERT_NEXT(a_result_after_search, clk, rst, load_out, state == npc_pkg::B_IDLE && result.valid, "result loaded outside finish")

endmodule

`default_nettype wire

### verif/palette_quant_checker.sv
`timescale 1ns / 1ps
// checker for the palette quantiser: tracks palette and count, predicts and compares each result
module palette_quant_checker (
  input  logic clk,
  input  logic rst,
  npc_in_if    item,
  npc_cfg_if   cfg,
  npc_out_if   result,
  output int   fail_count,
  output int   pending
);
  import npc_pkg::*;

  typedef struct packed {
    rgb_t       color;
    logic [7:0] index;
  } palette_match_t;

  rgb_t           palette_model [PALETTE_DEPTH];
  logic [8:0]     searched_count;
  palette_match_t expected_matches [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [DIST_W-1:0] colour_distance(rgb_t a, rgb_t b);
    logic [DIST_W-1:0] dr;
    logic [DIST_W-1:0] dg;
    logic [DIST_W-1:0] db;
    dr = (a.r > b.r) ? a.r - b.r : b.r - a.r;
    dg = (a.g > b.g) ? a.g - b.g : b.g - a.g;
    db = (a.b > b.b) ? a.b - b.b : b.b - a.b;
    return dr * dr + dg * dg + db * db;
  endfunction

  function automatic palette_match_t nearest_entry(rgb_t px);
    int                limit;
    int                best;
    logic [DIST_W-1:0] best_d;
    logic [DIST_W-1:0] d;
    palette_match_t    m;
    limit = (searched_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(searched_count);
    best = 0;
    best_d = '0;
    // strict compare keeps the lowest index on a tie
    for (int i = 0; i < limit; i++) begin
      d = colour_distance(px, palette_model[i]);
      if (i == 0 || d < best_d) begin
        best = i;
        best_d = d;
      end
    end
    m.color = palette_model[best];
    m.index = best[7:0];
    return m;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    palette_match_t want;
    if (rst) begin
      foreach (palette_model[i]) palette_model[i] = '0;
      searched_count = '0;
      expected_matches.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_matches.size() == 0) begin
          $error("result beat with no pixel waiting, best_index %0d", result.best_index);
          fail_count++;
        end else begin
          want = expected_matches.pop_front();
          check_field("red_out", want.color.r, result.red_out);
          check_field("green_out", want.color.g, result.green_out);
          check_field("blue_out", want.color.b, result.blue_out);
          check_field("best_index", want.index, result.best_index);
        end
      end
      if (cfg.valid && cfg.ready) begin
        searched_count = cfg.palette_count;
      end
      if (item.valid && item.ready) begin
        if (item.cmd == CMD_LOAD) begin
          palette_model[item.entry_index] = rgb_t'{item.red_in, item.green_in, item.blue_in};
        end else begin
          expected_matches.push_back(
            nearest_entry(rgb_t'{item.red_in, item.green_in, item.blue_in}));
        end
      end
    end
    pending <= expected_matches.size();
  end

endmodule

### verif/tb_nearest_palette_color.sv
`timescale 1ns / 1ps
// testbench top for the palette quantiser: clock, reset, stimulus, result stalls and verdict
module tb_nearest_palette_color;
  import npc_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  bit   quiet;
  int   beats_sent;

  npc_in_if  item_if ();
  npc_cfg_if cfg_if ();
  npc_out_if result_if ();

  nearest_palette_color dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .cfg    (cfg_if),
    .result (result_if)
  );

  palette_quant_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .item       (item_if),
    .cfg        (cfg_if),
    .result     (result_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_level(int style);
    case (style)
      1: begin
        case ($urandom_range(0, 2))
          0: return 8'd0;
          1: return 8'd128;
          default: return 8'd255;
        endcase
      end
      2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgb_t pick_colour(int style);
    return rgb_t'{pick_level(style), pick_level(style), pick_level(style)};
  endfunction

  task automatic send_beat(logic cmd, logic [7:0] idx, rgb_t c);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.cmd <= cmd;
    item_if.entry_index <= idx;
    item_if.red_in <= c.r;
    item_if.green_in <= c.g;
    item_if.blue_in <= c.b;
    do @(posedge clk); while (!item_if.ready);
    beats_sent++;
  endtask

  task automatic quantize(rgb_t c);
    send_beat(CMD_PIXEL, 8'($urandom_range(0, 255)), c);
  endtask

  task automatic load_entry(logic [7:0] idx, rgb_t c);
    send_beat(CMD_LOAD, idx, c);
  endtask

  // hold the sender until every pixel has come back, then let trailing loads retire
  task automatic drain();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_count(logic [8:0] n);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.palette_count <= n;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int hold;
    result_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = gap_len();
      if (hold > 0) begin
        result_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int         phase_len;
    int         eff;
    int         style;
    int         waited;
    logic [8:0] n;
    rst <= 1'b1;
    item_if.valid <= 1'b0;
    item_if.cmd <= CMD_LOAD;
    item_if.entry_index <= '0;
    item_if.red_in <= '0;
    item_if.green_in <= '0;
    item_if.blue_in <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.palette_count <= '0;
    quiet = 1'b0;
    beats_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // count of zero straight after reset: cleared entry 0
    quantize(rgb_t'{8'd0, 8'd0, 8'd0});
    quantize(rgb_t'{8'd255, 8'd255, 8'd255});
    load_entry(8'd0, rgb_t'{8'd255, 8'd255, 8'd255});
    load_entry(8'd255, rgb_t'{8'd10, 8'd20, 8'd30});
    load_entry(8'd1, rgb_t'{8'd255, 8'd255, 8'd255});
    load_entry(8'd2, rgb_t'{8'd0, 8'd0, 8'd0});
    quantize(rgb_t'{8'd200, 8'd200, 8'd200});
    set_count(9'd0);
    quantize(rgb_t'{8'd1, 8'd2, 8'd3});
    // entries 0 and 1 tie
    set_count(9'd3);
    quantize(rgb_t'{8'd250, 8'd250, 8'd250});
    quantize(rgb_t'{8'd0, 8'd0, 8'd0});
    quantize(rgb_t'{8'd10, 8'd20, 8'd30});
    set_count(9'd256);
    quantize(rgb_t'{8'd10, 8'd20, 8'd30});
    quantize(rgb_t'{8'd255, 8'd0, 8'd255});
    // count above depth saturates
    set_count(9'd511);
    quantize(rgb_t'{8'd11, 8'd21, 8'd31});
    set_count(9'd1);
    quantize(rgb_t'{8'd0, 8'd0, 8'd0});

    while (beats_sent < 400) begin
      case ($urandom_range(0, 99)) inside
        [0:7]:   n = 9'd0;
        [8:13]:  n = 9'd256;
        [14:16]: n = 9'($urandom_range(257, 511));
        [17:21]: n = 9'($urandom_range(100, 255));
        default: n = 9'($urandom_range(1, 24));
      endcase
      style = $urandom_range(0, 2);
      set_count(n);
      quiet = ($urandom_range(0, 3) == 0);
      eff = (n > 256) ? 256 : int'(n);
      if (eff <= 32) begin
        for (int i = 0; i < eff; i++) load_entry(8'(i), pick_colour(style));
      end
      phase_len = (eff > 64) ? $urandom_range(4, 12) : $urandom_range(15, 50);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 7) begin
          quantize($urandom_range(0, 1) ? pick_colour(style) : pick_colour(0));
        end else if (eff > 0 && $urandom_range(0, 9) < 7) begin
          load_entry(8'($urandom_range(0, eff - 1)), pick_colour(style));
        end else begin
          load_entry(8'($urandom_range(0, 255)), pick_colour(style));
        end
      end
    end

    quiet = 1'b0;
    item_if.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/npc_pkg.sv
hw/rtl/npc_if.sv
hw/rtl/npc_ram.sv
hw/rtl/npc_fifo.sv
hw/rtl/npc_front.sv
hw/rtl/npc_back.sv
hw/rtl/nearest_palette_color.sv
verif/palette_quant_checker.sv
verif/tb_nearest_palette_color.sv
